// ===== design/gaussian_soft_nms_assert.svh =====
// assertion macros shared by the checker
`ifndef GAUSSIAN_SOFT_NMS_ASSERT_SVH
`define GAUSSIAN_SOFT_NMS_ASSERT_SVH

// condition must never hold outside reset
`define GSN_NEVER(lbl, c, r, cond, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GSN_NEXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gsn_pkg.sv =====
`timescale 1ns / 1ps
package gsn_pkg;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [31:0] PIX_UNIT  = 32'h0002_0000;
    localparam logic [31:0] RECIP3    = 32'd699051;
    localparam logic [25:0] X_LIMIT   = 26'd1048576;
    localparam logic [16:0] IOU_ONE   = 17'h10000;
    localparam logic [15:0] INV_RESET = 16'd512;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCMP, ST_PICK, ST_SEL, ST_EMIT,
        ST_NEXT, ST_RD, ST_MUL, ST_IOU, ST_DIV, ST_WB
    } gsn_state_t;

    typedef enum logic [3:0] {
        STP_AA0, STP_AA1, STP_IW, STP_IH, STP_INTER, STP_AB0, STP_AB1, STP_SQ,
        STP_XS, STP_Y2, STP_Y3, STP_Y4, STP_D6, STP_D24, STP_POW, STP_SCORE
    } gsn_step_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } gsn_div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } gsn_div_rsp_t;

    // overlap along one axis in half-fraction units, negative when disjoint
    function automatic logic signed [19:0] gsn_overlap(input logic [15:0] ca,
                                                       input logic [15:0] sa,
                                                       input logic [15:0] cb,
                                                       input logic [15:0] sb);
        logic signed [19:0] la, ha, lb, hb, lo, hi;
        la = $signed({3'b0, ca, 1'b0}) - $signed({4'b0, sa});
        ha = $signed({3'b0, ca, 1'b0}) + $signed({4'b0, sa});
        lb = $signed({3'b0, cb, 1'b0}) - $signed({4'b0, sb});
        hb = $signed({3'b0, cb, 1'b0}) + $signed({4'b0, sb});
        lo = (la > lb) ? la : lb;
        hi = (ha < hb) ? ha : hb;
        return hi - lo;
    endfunction

endpackage

// ===== design/gsn_det_if.sv =====
`timescale 1ns / 1ps
interface gsn_det_if;
    logic        valid;
    logic        ready;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score_in;
    logic        last_in;

    modport source(output valid, center_x, center_y, box_width, box_height, score_in,
                   last_in, input ready);
    modport sink(input valid, center_x, center_y, box_width, box_height, score_in,
                 last_in, output ready);
endinterface

// ===== design/gsn_res_if.sv =====
`timescale 1ns / 1ps
interface gsn_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [15:0] out_score;
    logic [4:0]  load_index;
    logic        dropped;
    logic        last_out;

    modport source(output valid, out_x, out_y, out_width, out_height, out_score,
                   load_index, dropped, last_out, input ready);
    modport sink(input valid, out_x, out_y, out_width, out_height, out_score,
                 load_index, dropped, last_out, output ready);
endinterface

// ===== design/gsn_cfg_if.sv =====
`timescale 1ns / 1ps
interface gsn_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] inv_sigma;

    modport source(output valid, inv_sigma, input ready);
    modport sink(input valid, inv_sigma, output ready);
endinterface

// ===== design/gsn_mul.sv =====
`timescale 1ns / 1ps
module gsn_mul (
    input  logic                       clk,
    input  logic [gsn_pkg::MUL_A_W-1:0] a,
    input  logic [gsn_pkg::MUL_B_W-1:0] b,
    output logic [gsn_pkg::PROD_W-1:0]  prod
);
    import gsn_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;
endmodule

// ===== design/gsn_div.sv =====
`timescale 1ns / 1ps
module gsn_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gsn_pkg::gsn_div_req_t req,
    output gsn_pkg::gsn_div_rsp_t rsp
);
    import gsn_pkg::*;

    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [15:0] quot_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] rem_shift;
    logic        take;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg[63:0], 1'b0};
    assign take      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= {1'b0, req.num};
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quot_reg <= {quot_reg[14:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

// ===== design/gaussian_soft_nms.sv =====
`timescale 1ns / 1ps
// loading: one box per cycle while idle, nothing accepted during suppression
// per selection: a scan over every slot with a compare for each live box, then pick and
// emit, then the selected area, then per remaining box 21 multiplies on the one shared
// multiplier (fewer when the exponent is out of range) and a restoring divide, which is
// skipped when the boxes do not overlap or the intersection reaches the union
// reset (rst_n low, asynchronous) empties the table and sets inv_sigma to 512
module gaussian_soft_nms #(
    parameter int MAX_DETECTIONS = 32,
    parameter int IMAGE_WIDTH    = 768,
    parameter int IMAGE_HEIGHT   = 576
) (
    input logic        clk,
    input logic        rst_n,
    gsn_cfg_if.sink    cfg,
    gsn_det_if.sink    det,
    gsn_res_if.source  res
);
    import gsn_pkg::*;

    localparam int SLOTS = (MAX_DETECTIONS < 32) ? MAX_DETECTIONS : 32;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [31:0] W_C = 32'(IMAGE_WIDTH);
    localparam logic [31:0] H_C = 32'(IMAGE_HEIGHT);
    localparam logic [31:0] WH4 = 32'(4 * IMAGE_WIDTH * IMAGE_HEIGHT);

    gsn_state_t state_reg, state_next;
    gsn_step_t  step_reg, step_next;
    logic       phase_reg;
    logic [2:0] pow_cnt_reg;

    logic [CNT_W-1:0] count_reg, scan_i_reg, dec_i_reg;
    logic [SLOTS-1:0] mask_reg;
    logic             ovf_reg;
    logic [15:0]      inv_reg;
    logic [IDX_W-1:0] best_reg;
    logic             found_reg;
    logic [15:0]      best_score_reg;
    logic             res_valid_reg;

    logic [63:0] box_mem [SLOTS];
    logic [15:0] score_mem [SLOTS];
    logic [63:0] box_q;
    logic [15:0] score_q;
    logic [IDX_W-1:0] rd_addr;
    logic             sc_we;
    logic [IDX_W-1:0] sc_waddr;
    logic [15:0]      sc_wdata;
    logic             det_fire, load_we;

    logic [63:0] sel_box_reg;
    logic [63:0] cur_box_reg;
    logic [15:0] cur_score_reg;
    logic [17:0] dx_reg, dy_reg;
    logic        dx_neg_reg, dy_neg_reg;
    logic [31:0] iw_reg, ih_reg, tmp_reg;
    logic [63:0] inter_reg, area_a_reg, area_b_reg;
    logic [16:0] iou_reg;
    logic [33:0] sq_reg;
    logic [26:0] y_reg;
    logic [31:0] y2_reg, y3_reg, y4_reg, t6_reg, p_reg;

    logic [15:0] ox_reg, oy_reg, ow_reg, oh_reg, os_reg;
    logic [4:0]  oi_reg;
    logic        od_reg, ol_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [25:0]        x_val;
    logic               x_big;
    logic [33:0]        p_sum;
    logic signed [65:0] uni;
    logic               iou_zero, iou_sat;
    logic signed [19:0] ov_x, ov_y;
    logic [SLOTS-1:0]   best_bit;

    gsn_div_req_t div_req;
    gsn_div_rsp_t div_rsp;

    gsn_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
    gsn_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign det.ready = (state_reg == ST_IDLE);
    assign cfg.ready = (state_reg == ST_IDLE);
    assign det_fire  = det.valid && (state_reg == ST_IDLE);
    assign load_we   = det_fire && (count_reg < CNT_W'(SLOTS));

    assign res.valid      = res_valid_reg;
    assign res.out_x      = ox_reg;
    assign res.out_y      = oy_reg;
    assign res.out_width  = ow_reg;
    assign res.out_height = oh_reg;
    assign res.out_score  = os_reg;
    assign res.load_index = oi_reg;
    assign res.dropped    = od_reg;
    assign res.last_out   = ol_reg;

    // box and score tables
    always_comb
    begin
        unique case (state_reg)
            ST_SCAN: rd_addr = scan_i_reg[IDX_W-1:0];
            ST_PICK: rd_addr = best_reg;
            default: rd_addr = dec_i_reg[IDX_W-1:0];
        endcase
        sc_we    = load_we || (state_reg == ST_WB);
        sc_waddr = (state_reg == ST_WB) ? dec_i_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];
        sc_wdata = (state_reg == ST_WB) ? cur_score_reg : det.score_in;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            box_mem[count_reg[IDX_W-1:0]] <= {det.box_height, det.box_width,
                                              det.center_y, det.center_x};
        end
        if (sc_we)
        begin
            score_mem[sc_waddr] <= sc_wdata;
        end
        box_q   <= box_mem[rd_addr];
        score_q <= score_mem[rd_addr];
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (step_reg)
            STP_AA0:   begin mul_a = 34'(sel_box_reg[47:32]); mul_b = 32'(sel_box_reg[63:48]); end
            STP_AA1:   begin mul_a = 34'(tmp_reg);            mul_b = WH4; end
            STP_IW:    begin mul_a = 34'(dx_reg);             mul_b = W_C; end
            STP_IH:    begin mul_a = 34'(dy_reg);             mul_b = H_C; end
            STP_INTER: begin mul_a = 34'(iw_reg);             mul_b = ih_reg; end
            STP_AB0:   begin mul_a = 34'(cur_box_reg[47:32]); mul_b = 32'(cur_box_reg[63:48]); end
            STP_AB1:   begin mul_a = 34'(tmp_reg);            mul_b = WH4; end
            STP_SQ:    begin mul_a = 34'(iou_reg);            mul_b = 32'(iou_reg); end
            STP_XS:    begin mul_a = sq_reg;                  mul_b = 32'(inv_reg); end
            STP_Y2:    begin mul_a = 34'(y_reg);              mul_b = 32'(y_reg); end
            STP_Y3:    begin mul_a = 34'(y2_reg);             mul_b = 32'(y_reg); end
            STP_Y4:    begin mul_a = 34'(y3_reg);             mul_b = 32'(y_reg); end
            STP_D6:    begin mul_a = 34'(y3_reg >> 1);        mul_b = RECIP3; end
            STP_D24:   begin mul_a = 34'(y4_reg >> 3);        mul_b = RECIP3; end
            STP_POW:   begin mul_a = 34'(p_reg);              mul_b = p_reg; end
            STP_SCORE: begin mul_a = 34'(cur_score_reg);      mul_b = p_reg; end
            default:   begin mul_a = '0;                      mul_b = '0; end
        endcase
    end

    assign x_val = prod[49:24];
    assign x_big = x_val >= X_LIMIT;
    assign p_sum = 34'(ONE_Q31) - 34'(y_reg) + 34'(y2_reg >> 1) - 34'(t6_reg)
                 + 34'(prod[52:21]);
    assign uni   = $signed({2'b0, area_a_reg}) + $signed({2'b0, area_b_reg})
                 - $signed({2'b0, inter_reg});
    assign iou_zero = (iw_reg == '0) || (ih_reg == '0);
    assign iou_sat  = uni <= $signed({2'b0, inter_reg});
    assign ov_x = gsn_overlap(sel_box_reg[15:0], sel_box_reg[47:32], box_q[15:0], box_q[47:32]);
    assign ov_y = gsn_overlap(sel_box_reg[31:16], sel_box_reg[63:48], box_q[31:16],
                              box_q[63:48]);
    assign best_bit = SLOTS'(1) << best_reg;

    assign div_req.start = (state_reg == ST_IOU) && !iou_zero && !iou_sat;
    assign div_req.num   = inter_reg;
    assign div_req.den   = uni[63:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STP_AA0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (det_fire && det.last_in)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (scan_i_reg == CNT_W'(SLOTS))
                    state_next = ST_PICK;
                else if (mask_reg[scan_i_reg[IDX_W-1:0]])
                    state_next = ST_SCMP;
                else
                    state_next = ST_SCAN;
            end
            ST_SCMP: state_next = ST_SCAN;
            ST_PICK: state_next = ST_SEL;
            ST_SEL:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (res.ready)
                begin
                    if (mask_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        step_next  = STP_AA0;
                    end
                end
            end
            ST_NEXT:
            begin
                priority if (dec_i_reg == CNT_W'(SLOTS))
                    state_next = ST_SCAN;
                else if (mask_reg[dec_i_reg[IDX_W-1:0]])
                    state_next = ST_RD;
                else
                    state_next = ST_NEXT;
            end
            ST_RD:
            begin
                state_next = ST_MUL;
                step_next  = STP_IW;
            end
            ST_MUL:
            begin
                if (phase_reg)
                begin
                    unique case (step_reg)
                        STP_AA0:   step_next = STP_AA1;
                        STP_AA1:   state_next = ST_NEXT;
                        STP_IW:    step_next = STP_IH;
                        STP_IH:    step_next = STP_INTER;
                        STP_INTER: step_next = STP_AB0;
                        STP_AB0:   step_next = STP_AB1;
                        STP_AB1:   state_next = ST_IOU;
                        STP_SQ:    step_next = STP_XS;
                        STP_XS:    step_next = x_big ? STP_SCORE : STP_Y2;
                        STP_Y2:    step_next = STP_Y3;
                        STP_Y3:    step_next = STP_Y4;
                        STP_Y4:    step_next = STP_D6;
                        STP_D6:    step_next = STP_D24;
                        STP_D24:   step_next = STP_POW;
                        STP_POW:   step_next = (pow_cnt_reg == 3'd7) ? STP_SCORE : STP_POW;
                        STP_SCORE: state_next = ST_WB;
                        default:   step_next = STP_AA0;
                    endcase
                end
            end
            ST_IOU:
            begin
                if (div_req.start)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_MUL;
                    step_next  = STP_SQ;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MUL;
                    step_next  = STP_SQ;
                end
            end
            ST_WB:   state_next = ST_NEXT;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            count_reg     <= '0;
            mask_reg      <= '0;
            ovf_reg       <= 1'b0;
            inv_reg       <= INV_RESET;
            res_valid_reg <= 1'b0;
            scan_i_reg    <= '0;
            dec_i_reg     <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            pow_cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= (state_reg == ST_MUL) ? !phase_reg : 1'b0;
            if (cfg.valid && (state_reg == ST_IDLE))
            begin
                inv_reg <= cfg.inv_sigma;
            end
            if (det_fire)
            begin
                if (load_we)
                begin
                    mask_reg  <= mask_reg | (SLOTS'(1) << count_reg[IDX_W-1:0]);
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (state_next == ST_SCAN && state_reg != ST_SCAN && state_reg != ST_SCMP)
            begin
                scan_i_reg <= '0;
                found_reg  <= 1'b0;
            end
            else if (state_reg == ST_SCAN && scan_i_reg != CNT_W'(SLOTS)
                     && !mask_reg[scan_i_reg[IDX_W-1:0]])
            begin
                scan_i_reg <= scan_i_reg + CNT_W'(1);
            end
            else if (state_reg == ST_SCMP)
            begin
                // strict compare keeps the earliest box on a tie
                if (!found_reg || score_q > best_score_reg)
                begin
                    best_reg <= scan_i_reg[IDX_W-1:0];
                    found_reg <= 1'b1;
                end
                scan_i_reg <= scan_i_reg + CNT_W'(1);
            end
            if (state_reg == ST_SEL)
            begin
                mask_reg      <= mask_reg & ~best_bit;
                res_valid_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT && res.ready)
            begin
                res_valid_reg <= 1'b0;
                dec_i_reg     <= '0;
                if (mask_reg == '0)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
            if ((state_reg == ST_NEXT && dec_i_reg != CNT_W'(SLOTS)
                 && !mask_reg[dec_i_reg[IDX_W-1:0]]) || state_reg == ST_WB)
            begin
                dec_i_reg <= dec_i_reg + CNT_W'(1);
            end
            if (state_reg == ST_MUL && phase_reg)
            begin
                if (step_reg == STP_D24)
                    pow_cnt_reg <= '0;
                else if (step_reg == STP_POW)
                    pow_cnt_reg <= pow_cnt_reg + 3'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCMP && (!found_reg || score_q > best_score_reg))
        begin
            best_score_reg <= score_q;
        end
        if (state_reg == ST_SEL)
        begin
            sel_box_reg <= box_q;
            ox_reg      <= box_q[15:0];
            oy_reg      <= box_q[31:16];
            ow_reg      <= box_q[47:32];
            oh_reg      <= box_q[63:48];
            os_reg      <= score_q;
            oi_reg      <= 5'(best_reg);
            od_reg      <= ovf_reg;
            ol_reg      <= (mask_reg & ~best_bit) == '0;
        end
        if (state_reg == ST_RD)
        begin
            cur_box_reg   <= box_q;
            cur_score_reg <= score_q;
            dx_reg        <= ov_x[17:0];
            dx_neg_reg    <= ov_x[19];
            dy_reg        <= ov_y[17:0];
            dy_neg_reg    <= ov_y[19];
        end
        if (state_reg == ST_IOU)
        begin
            iou_reg <= iou_zero ? 17'd0 : IOU_ONE;
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            iou_reg <= {1'b0, div_rsp.quot};
        end
        if (state_reg == ST_MUL && phase_reg)
        begin
            unique case (step_reg)
                STP_AA0, STP_AB0: tmp_reg <= prod[31:0];
                STP_AA1:   area_a_reg <= prod[63:0];
                STP_AB1:   area_b_reg <= prod[63:0];
                STP_IW:    iw_reg <= dx_neg_reg ? 32'd0 : prod[31:0] + PIX_UNIT;
                STP_IH:    ih_reg <= dy_neg_reg ? 32'd0 : prod[31:0] + PIX_UNIT;
                STP_INTER: inter_reg <= prod[63:0];
                STP_SQ:    sq_reg <= prod[33:0];
                STP_XS:
                begin
                    y_reg <= {x_val[19:0], 7'b0};
                    if (x_big)
                        p_reg <= '0;
                end
                STP_Y2:    y2_reg <= prod[62:31];
                STP_Y3:    y3_reg <= prod[62:31];
                STP_Y4:    y4_reg <= prod[62:31];
                STP_D6:    t6_reg <= prod[52:21];
                STP_D24:   p_reg <= p_sum[31:0];
                STP_POW:   p_reg <= prod[62:31];
                STP_SCORE: cur_score_reg <= prod[46:31];
                default:   tmp_reg <= tmp_reg;
            endcase
        end
    end
endmodule

// ===== design/gsn_checker.sv =====
`timescale 1ns / 1ps
`include "gaussian_soft_nms_assert.svh"
module gsn_props (
    input logic        clk,
    input logic        rst_n,
    input logic        det_ready,
    input logic        cfg_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_last,
    input logic [15:0] res_score,
    input logic [4:0]  res_index
);
    `GSN_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
              res_valid && $stable(res_score) && $stable(res_index),
              "result changed while stalled")
    `GSN_NEVER(a_busy_out, clk, rst_n, det_ready && res_valid,
               "input ready while a result is pending")
    `GSN_NEXT(a_last_idle, clk, rst_n, res_valid && res_ready && res_last,
              det_ready && !res_valid, "not idle after last result")
    `GSN_NEVER(a_cfg_ready, clk, rst_n, det_ready != cfg_ready,
               "config and input ready disagree")
endmodule

bind gaussian_soft_nms gsn_props u_gsn_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .det_ready (det.ready),
    .cfg_ready (cfg.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_last  (res.last_out),
    .res_score (res.out_score),
    .res_index (res.load_index)
);

// ===== tb/gsn_checker.sv =====
`timescale 1ns / 1ps
module gsn_checker #(
    parameter int MAX_DETECTIONS = 32,
    parameter int IMAGE_WIDTH    = 768,
    parameter int IMAGE_HEIGHT   = 576
) (
    input  logic clk,
    input  logic rst_n,
    gsn_cfg_if   cfg,
    gsn_det_if   det,
    gsn_res_if   res,
    output int   error_count,
    output int   pending_picks,
    output int   picks_seen
);

    localparam int SLOT_COUNT = (MAX_DETECTIONS < 32) ? MAX_DETECTIONS : 32;
    localparam longint unsigned Q31_ONE = 64'd1 << 31;
    localparam longint PIXEL_STEP = 64'sd1 << 17;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] score;
        logic [4:0]  idx;
        logic        dropped;
        logic        last;
    } pick_t;

    logic [15:0] box_x [32];
    logic [15:0] box_y [32];
    logic [15:0] box_w [32];
    logic [15:0] box_h [32];
    logic [15:0] box_score [32];
    logic [31:0] live;
    int          loaded;
    logic        overflowed;
    logic [15:0] sigma_recip;
    pick_t       expected_picks [$];

    function automatic longint axis_overlap(input logic [15:0] ca, input logic [15:0] sa,
                                            input logic [15:0] cb, input logic [15:0] sb,
                                            input longint scale);
        longint la, ha, lb, hb, lo, hi;
        la = (2 * longint'(ca) - longint'(sa)) * scale;
        ha = (2 * longint'(ca) + longint'(sa)) * scale;
        lb = (2 * longint'(cb) - longint'(sb)) * scale;
        hb = (2 * longint'(cb) + longint'(sb)) * scale;
        lo = (la > lb) ? la : lb;
        hi = (ha < hb) ? ha : hb;
        if (hi < lo)
            return 0;
        return hi - lo + PIXEL_STEP;
    endfunction

    function automatic longint unsigned overlap_ratio(input int a, input int b);
        longint iw, ih, inter, area_a, area_b, uni;
        longint unsigned rem, q;
        iw = axis_overlap(box_x[a], box_w[a], box_x[b], box_w[b], IMAGE_WIDTH);
        ih = axis_overlap(box_y[a], box_h[a], box_y[b], box_h[b], IMAGE_HEIGHT);
        if (iw == 0 || ih == 0)
            return 0;
        inter = iw * ih;
        area_a = (2 * longint'(box_w[a]) * IMAGE_WIDTH) * (2 * longint'(box_h[a]) * IMAGE_HEIGHT);
        area_b = (2 * longint'(box_w[b]) * IMAGE_WIDTH) * (2 * longint'(box_h[b]) * IMAGE_HEIGHT);
        uni = area_a + area_b - inter;
        // one-pixel rule can push the intersection past the union
        if (uni <= inter)
            return 65536;
        rem = inter;
        q = 0;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= longint'(uni))
            begin
                rem = rem - uni;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned gauss_factor(input longint unsigned x);
        longint unsigned y, y2, y3, y4, p;
        if (x >= (64'd16 << 16))
            return 0;
        y = x << 7;
        y2 = (y * y) >> 31;
        y3 = (y2 * y) >> 31;
        y4 = (y3 * y) >> 31;
        p = Q31_ONE - y + (y2 >> 1) - y3 / 6 + y4 / 24;
        for (int i = 0; i < 8; i++)
            p = (p * p) >> 31;
        return p;
    endfunction

    task automatic run_suppression();
        int best;
        pick_t pk;
        longint unsigned ov, ex;
        while (live != 0)
        begin
            best = -1;
            for (int i = 0; i < SLOT_COUNT; i++)
                if (live[i] && (best < 0 || box_score[i] > box_score[best]))
                    best = i;
            live[best] = 1'b0;
            pk.x = box_x[best];
            pk.y = box_y[best];
            pk.w = box_w[best];
            pk.h = box_h[best];
            pk.score = box_score[best];
            pk.idx = best[4:0];
            pk.dropped = overflowed;
            pk.last = (live == 0);
            expected_picks.push_back(pk);
            for (int i = 0; i < SLOT_COUNT; i++)
                if (live[i])
                begin
                    ov = overlap_ratio(best, i);
                    ex = (ov * ov * longint'(sigma_recip)) >> 24;
                    box_score[i] = 16'((longint'(box_score[i]) * gauss_factor(ex)) >> 31);
                end
        end
        live = 0;
        loaded = 0;
        overflowed = 1'b0;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("checker: mismatch on %s, got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pick_t pk;
        if (!rst_n)
        begin
            live = 0;
            loaded = 0;
            overflowed = 1'b0;
            sigma_recip = 16'd512;
            error_count = 0;
            picks_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                sigma_recip = cfg.inv_sigma;
            if (det.valid && det.ready)
            begin
                if (loaded < SLOT_COUNT)
                begin
                    box_x[loaded] = det.center_x;
                    box_y[loaded] = det.center_y;
                    box_w[loaded] = det.box_width;
                    box_h[loaded] = det.box_height;
                    box_score[loaded] = det.score_in;
                    live[loaded] = 1'b1;
                    loaded++;
                end
                else
                    overflowed = 1'b1;
                if (det.last_in)
                    run_suppression();
            end
            if (res.valid && res.ready)
            begin
                picks_seen++;
                if (expected_picks.size() == 0)
                begin
                    $display("checker: result transaction with nothing expected");
                    error_count++;
                end
                else
                begin
                    pk = expected_picks.pop_front();
                    if (res.out_x !== pk.x) report("out_x", res.out_x, pk.x);
                    if (res.out_y !== pk.y) report("out_y", res.out_y, pk.y);
                    if (res.out_width !== pk.w) report("out_width", res.out_width, pk.w);
                    if (res.out_height !== pk.h) report("out_height", res.out_height, pk.h);
                    if (res.out_score !== pk.score) report("out_score", res.out_score, pk.score);
                    if (res.load_index !== pk.idx) report("load_index", res.load_index, pk.idx);
                    if (res.dropped !== pk.dropped) report("dropped", res.dropped, pk.dropped);
                    if (res.last_out !== pk.last) report("last_out", res.last_out, pk.last);
                end
            end
        end
        pending_picks = expected_picks.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    int   error_count, pending_picks, picks_seen;
    int   items_sent, sets_sent, idle_cycles;
    int   send_idle_pct, recv_stall_pct;

    gsn_cfg_if cfg ();
    gsn_det_if det ();
    gsn_res_if res ();

    gaussian_soft_nms u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .det   (det),
        .res   (res)
    );

    gsn_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .det           (det),
        .res           (res),
        .error_count   (error_count),
        .pending_picks (pending_picks),
        .picks_seen    (picks_seen)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    always @(negedge clk)
        res.ready <= ($urandom_range(99) >= recv_stall_pct);

    // nothing accepted on any channel for too long means a hang
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((det.valid && det.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    task automatic send_box(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] s, input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            det.valid <= 1'b0;
            @(negedge clk);
        end
        det.valid <= 1'b1;
        det.center_x <= cx;
        det.center_y <= cy;
        det.box_width <= w;
        det.box_height <= h;
        det.score_in <= s;
        det.last_in <= lst;
        do
            @(posedge clk);
        while (!det.ready);
        items_sent++;
        if (lst)
            sets_sent++;
    endtask

    // register writes only once the block has drained
    task automatic write_sigma(input logic [15:0] v);
        @(negedge clk);
        det.valid <= 1'b0;
        while (pending_picks != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.inv_sigma <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_set(input int n);
        logic [15:0] bx, by, bw, bh, s;
        bx = 16'($urandom);
        by = 16'($urandom);
        bw = 16'($urandom_range(40000, 1000));
        bh = 16'($urandom_range(40000, 1000));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                // clustered boxes overlap and exercise the decay
                if (i == 0 || $urandom_range(3) == 0)
                begin
                    bx = 16'($urandom);
                    by = 16'($urandom);
                    bw = 16'($urandom_range(40000, 1000));
                    bh = 16'($urandom_range(40000, 1000));
                end
                bx = bx + 16'($urandom_range(4000)) - 16'd2000;
                by = by + 16'($urandom_range(4000)) - 16'd2000;
                bw = bw + 16'($urandom_range(2000));
                bh = bh + 16'($urandom_range(2000));
                case ($urandom_range(9))
                    0: s = 16'd0;
                    1: s = 16'hffff;
                    default: s = 16'($urandom);
                endcase
                send_box(bx, by, bw, bh, s, i == n - 1);
            end
            else
                send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), i == n - 1);
        end
    endtask

    initial
    begin
        int n;
        logic [15:0] sigmas [4];
        int send_pct [4];
        int stall_pct [4];
        sigmas = '{16'd1, 16'hffff, 16'd512, 16'd0};
        send_pct = '{0, 56, 0, 25};
        stall_pct = '{0, 0, 56, 25};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        sets_sent = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.inv_sigma = 16'd0;
        det.valid = 1'b0;
        det.center_x = 16'd0;
        det.center_y = 16'd0;
        det.box_width = 16'd0;
        det.box_height = 16'd0;
        det.score_in = 16'd0;
        det.last_in = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ties, tiny boxes, disjoint boxes, extremes at reset sigma
        send_box(16'd32768, 16'd32768, 16'd16384, 16'd16384, 16'hffff, 1'b0);
        send_box(16'd32768, 16'd32768, 16'd16384, 16'd16384, 16'hffff, 1'b0);
        send_box(16'd100, 16'd100, 16'd0, 16'd0, 16'd40000, 1'b0);
        send_box(16'd100, 16'd100, 16'd0, 16'd0, 16'd30000, 1'b0);
        send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'd1, 1'b0);
        send_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 1'b0);
        send_box(16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 1'b1);
        // all-zero scores come out in load order
        send_box(16'd20000, 16'd20000, 16'd8000, 16'd8000, 16'd0, 1'b0);
        send_box(16'd20500, 16'd20100, 16'd8000, 16'd8000, 16'd0, 1'b0);
        send_box(16'd50000, 16'd9000, 16'd3000, 16'd5000, 16'd0, 1'b1);
        // single box set
        send_box(16'hffff, 16'd0, 16'hffff, 16'd0, 16'h8000, 1'b1);
        write_sigma(16'hffff);
        send_box(16'd30000, 16'd30000, 16'd20000, 16'd20000, 16'd60000, 1'b0);
        send_box(16'd30500, 16'd30300, 16'd20000, 16'd19000, 16'd59000, 1'b0);
        send_box(16'd31000, 16'd29000, 16'd21000, 16'd20000, 16'd58000, 1'b1);
        write_sigma(16'd1);
        send_box(16'd30000, 16'd30000, 16'd20000, 16'd20000, 16'd60000, 1'b0);
        send_box(16'd30500, 16'd30300, 16'd20000, 16'd19000, 16'd59000, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 3)
                sigmas[3] = 16'($urandom_range(65535, 1));
            write_sigma(sigmas[ph]);
            send_idle_pct = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            if (ph == 1)
                random_set(34);
            while (items_sent < 20 + 90 * (ph + 1))
            begin
                case ($urandom_range(19))
                    0: n = $urandom_range(16, 8);
                    1: n = 1;
                    default: n = $urandom_range(6, 2);
                endcase
                random_set(n);
            end
        end
        write_sigma(16'd512);
        random_set(32);

        @(negedge clk);
        det.valid <= 1'b0;
        while (pending_picks != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d boxes in %0d sets, %0d results checked", items_sent, sets_sent,
                 picks_seen);
        $display("tb: sigma extremes, ties, tiny and disjoint boxes, zero scores, overflow");
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/gsn_pkg.sv
design/gsn_det_if.sv
design/gsn_res_if.sv
design/gsn_cfg_if.sv
design/gsn_mul.sv
design/gsn_div.sv
design/gaussian_soft_nms.sv
design/gsn_checker.sv
tb/gsn_checker.sv
tb/tb.sv
